// File: src/ihrc_pkg.sv
// Shared types and constants for the IPv4 header rewrite and checksum block.
package ihrc_pkg;

    localparam logic [6:0] POS_ETYPE_HI = 7'd12;
    localparam logic [6:0] POS_ETYPE_LO = 7'd13;
    localparam logic [6:0] POS_IP_START = 7'd14;
    localparam logic [6:0] POS_TOS      = 7'd15;
    localparam logic [6:0] POS_CK_HI    = 7'd24;
    localparam logic [6:0] POS_CK_LO    = 7'd25;
    localparam logic [6:0] POS_SRC_LOW  = 7'd29;
    localparam logic [6:0] POS_MAX      = 7'd127;

    localparam logic [7:0] ETYPE_IPV4_HI = 8'h08;
    localparam logic [7:0] ETYPE_IPV4_LO = 8'h00;

    localparam logic [7:0] TOS_RESET     = 8'd7;
    localparam logic [5:0] SRC_LOW_RESET = 6'd0;

    // Configuration register indexes (paddr[2]).
    localparam logic REG_NEW_TOS = 1'b0;
    localparam logic REG_SRC_LOW = 1'b1;

    typedef enum logic
    {
        ST_RUN,
        ST_FLUSH
    } ctrl_state_t;

    typedef struct packed
    {
        logic accept;
        logic issue;
        logic pop_last;
        logic advance;
        logic clear;
    } ctrl_cmd_t;

    typedef struct packed
    {
        logic full;
        logic fill_zero;
        logic fill_one;
        logic pend_valid;
        logic out_valid;
    } dp_status_t;

endpackage

// File: src/ipv4_header_rewrite_checksum_top.sv
// Top level of the IPv4 header rewrite and checksum block, with its APB register port.
//
//  Channel   Direction  Handshake               Payload
//  s_axis    in         tvalid/tready           tdata = frame_byte, tlast = frame_end
//  m_axis    out        tvalid/tready           tdata = out_byte, tlast = out_end
//  apb       in         psel/penable/pready     new_tos (0x0), source_low_octet (0x4)
//
// One byte transfer is taken per cycle while m_axis keeps up. Once DELAY_DEPTH bytes are
// held, each transfer pops the oldest byte through the single ring read port, and that byte
// passes through the ring read register and then the output register to m_axis. After the
// tlast transfer the input is held off while the held bytes drain. Reset clears the control
// state only, since a ring slot is read only after it is written. A stall on m_axis holds
// the output register and, once a popped byte waits behind it, the input.
module ipv4_header_rewrite_checksum_top
#(
    parameter int DELAY_DEPTH = 60
)
(
    input  logic        clk,
    input  logic        rst_n,
    // s_axis_tdata bits [7:0]: frame_byte
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tlast,
    // m_axis_tdata bits [7:0]: out_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ihrc_pkg::*;

    localparam int PTR_W = $clog2(DELAY_DEPTH);
    localparam int CNT_W = $clog2(DELAY_DEPTH + 1);

    logic [7:0] new_tos_reg;
    logic [5:0] src_low_reg;
    logic       cfg_write;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // The APB port never waits; a write lands at the end of the access phase.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            new_tos_reg <= TOS_RESET;
            src_low_reg <= SRC_LOW_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_NEW_TOS: new_tos_reg <= pwdata[7:0];
                REG_SRC_LOW: src_low_reg <= pwdata[5:0];
                default:     new_tos_reg <= new_tos_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_NEW_TOS: prdata = {24'd0, new_tos_reg};
            REG_SRC_LOW: prdata = {26'd0, src_low_reg};
            default:     prdata = '0;
        endcase
    end

    // The controller decides on every transfer; the datapath only carries them out.
    ihrc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_last   (s_axis_tlast),
        .in_ready  (s_axis_tready),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    ihrc_datapath
    #(
        .DELAY_DEPTH (DELAY_DEPTH),
        .PTR_W       (PTR_W),
        .CNT_W       (CNT_W)
    )
    u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .in_byte          (s_axis_tdata),
        .new_tos          (new_tos_reg),
        .source_low_octet (src_low_reg),
        .out_ready        (m_axis_tready),
        .out_valid        (m_axis_tvalid),
        .out_byte         (m_axis_tdata),
        .out_end          (m_axis_tlast)
    );

endmodule

// File: src/ihrc_ctrl.sv
// Controller state machine: input handshake, delay line reads and end-of-frame flush.
module ihrc_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_last,
    output logic                in_ready,
    input  logic                out_ready,
    input  ihrc_pkg::dp_status_t status,
    output ihrc_pkg::ctrl_cmd_t  cmd
);
    import ihrc_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        slot_free;
    logic        can_issue;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        slot_free   = !status.out_valid || out_ready;
        can_issue   = !status.pend_valid || slot_free;
        cmd.advance = status.pend_valid && slot_free;
        unique case (state_reg)
            ST_RUN:
            begin
                in_ready   = can_issue;
                cmd.accept = in_valid && can_issue;
                cmd.issue  = cmd.accept && status.full;
                if (cmd.accept && in_last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                cmd.issue    = can_issue && !status.fill_zero;
                cmd.pop_last = cmd.issue && status.fill_one;
                if (status.fill_zero && !status.pend_valid)
                begin
                    cmd.clear  = 1'b1;
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

endmodule

// File: src/ihrc_datapath.sv
// Datapath: header rewrite, checksum accumulation, delay line ring and output register.
module ihrc_datapath
#(
    parameter int DELAY_DEPTH = 60,
    parameter int PTR_W       = 6,
    parameter int CNT_W       = 6
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ihrc_pkg::ctrl_cmd_t  cmd,
    output ihrc_pkg::dp_status_t status,
    input  logic [7:0]           in_byte,
    input  logic [7:0]           new_tos,
    input  logic [5:0]           source_low_octet,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [7:0]           out_byte,
    output logic                 out_end
);
    import ihrc_pkg::*;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DELAY_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DELAY_DEPTH - 1);
    localparam logic [CNT_W:0]   DEPTH_SUM = (CNT_W + 1)'(DELAY_DEPTH);

    logic [7:0]       mem [DELAY_DEPTH];
    logic [7:0]       rd_data_reg;

    logic [PTR_W-1:0] head_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [6:0]       pos_reg;
    logic [6:0]       opos_reg;
    logic             is_ipv4_reg;
    logic [3:0]       hdr_words_reg;
    logic [21:0]      sum_reg;
    logic             pend_valid_reg;
    logic             pend_last_reg;
    logic [6:0]       pend_pos_reg;
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             out_end_reg;

    logic [PTR_W-1:0] head_next;
    logic [CNT_W-1:0] fill_next;
    logic             is_ipv4_next;
    logic [3:0]       hdr_words_eff;
    logic [6:0]       hdr_end;
    logic [7:0]       wbyte;
    logic [21:0]      sum_next;
    logic [CNT_W:0]   wr_sum;
    logic [PTR_W-1:0] wr_ptr;
    logic             in_header;
    logic [16:0]      fold1;
    logic [16:0]      fold2;
    logic [15:0]      checksum;
    logic [7:0]       pop_byte;

    // Write slot sits fill entries past the oldest one, modulo the ring size.
    always_comb
    begin
        wr_sum = {1'b0, head_reg} + {1'b0, fill_reg};
        if (wr_sum >= DEPTH_SUM)
        begin
            wr_sum = wr_sum - DEPTH_SUM;
        end
        wr_ptr = wr_sum[PTR_W-1:0];
    end

    always_comb
    begin
        is_ipv4_next = is_ipv4_reg;
        if (pos_reg == POS_ETYPE_HI)
        begin
            is_ipv4_next = (in_byte == ETYPE_IPV4_HI);
        end
        else if (pos_reg == POS_ETYPE_LO)
        begin
            is_ipv4_next = is_ipv4_reg && (in_byte == ETYPE_IPV4_LO);
        end

        hdr_words_eff = (pos_reg == POS_IP_START) ? in_byte[3:0] : hdr_words_reg;
        hdr_end       = POS_IP_START + {1'b0, hdr_words_eff, 2'b00};

        wbyte = in_byte;
        if (is_ipv4_next && pos_reg == POS_TOS)
        begin
            wbyte = new_tos;
        end
        if (is_ipv4_next && pos_reg == POS_SRC_LOW)
        begin
            wbyte = {2'b00, source_low_octet};
        end

        in_header = is_ipv4_next && (pos_reg >= POS_IP_START) && (pos_reg < hdr_end)
                    && (pos_reg != POS_CK_HI) && (pos_reg != POS_CK_LO);
        sum_next = sum_reg;
        if (in_header)
        begin
            // Header offset parity equals the frame position parity.
            if (!pos_reg[0])
            begin
                sum_next = sum_reg + {6'd0, wbyte, 8'd0};
            end
            else
            begin
                sum_next = sum_reg + {14'd0, wbyte};
            end
        end
    end

    always_comb
    begin
        fold1    = {1'b0, sum_reg[15:0]} + {11'd0, sum_reg[21:16]};
        fold2    = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};
        checksum = ~fold2[15:0];
        pop_byte = rd_data_reg;
        if (is_ipv4_reg && pend_pos_reg == POS_CK_HI)
        begin
            pop_byte = checksum[15:8];
        end
        else if (is_ipv4_reg && pend_pos_reg == POS_CK_LO)
        begin
            pop_byte = checksum[7:0];
        end
    end

    always_comb
    begin
        head_next = head_reg;
        if (cmd.issue)
        begin
            head_next = (head_reg == LAST_PTR) ? '0 : head_reg + 1'b1;
        end
        fill_next = fill_reg;
        if (cmd.accept && !cmd.issue)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (!cmd.accept && cmd.issue)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    // Ring memory: read-first, so a pop and a push on the same slot see the old byte.
    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            rd_data_reg <= mem[head_reg];
        end
        if (cmd.accept)
        begin
            mem[wr_ptr] <= wbyte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            fill_reg       <= '0;
            pos_reg        <= '0;
            opos_reg       <= '0;
            is_ipv4_reg    <= 1'b0;
            hdr_words_reg  <= '0;
            sum_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                head_reg      <= '0;
                fill_reg      <= '0;
                pos_reg       <= '0;
                opos_reg      <= '0;
                is_ipv4_reg   <= 1'b0;
                hdr_words_reg <= '0;
                sum_reg       <= '0;
            end
            else
            begin
                head_reg <= head_next;
                fill_reg <= fill_next;
                if (cmd.accept)
                begin
                    is_ipv4_reg   <= is_ipv4_next;
                    hdr_words_reg <= (is_ipv4_next && pos_reg == POS_IP_START)
                                     ? in_byte[3:0] : hdr_words_reg;
                    sum_reg       <= sum_next;
                    pos_reg       <= (pos_reg == POS_MAX) ? POS_MAX : pos_reg + 1'b1;
                end
                if (cmd.issue)
                begin
                    opos_reg <= (opos_reg == POS_MAX) ? POS_MAX : opos_reg + 1'b1;
                end
            end

            if (cmd.issue)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.advance)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (cmd.advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            pend_pos_reg  <= opos_reg;
            pend_last_reg <= cmd.pop_last;
        end
        if (cmd.advance)
        begin
            out_byte_reg <= pop_byte;
            out_end_reg  <= pend_last_reg;
        end
    end

    assign status.full       = (fill_reg == DEPTH_CNT);
    assign status.fill_zero  = (fill_reg == '0);
    assign status.fill_one   = (fill_reg == CNT_W'(1));
    assign status.pend_valid = pend_valid_reg;
    assign status.out_valid  = out_valid_reg;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_end   = out_end_reg;

endmodule

// File: src/ihrc_checker.sv
// Port-level checker for the IPv4 header rewrite block, bound to the top level.
module ihrc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata
);

    // A stalled output byte holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output byte changed while stalled");

    // The last byte of a frame starts the flush, which holds off the input.
    a_flush_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input accepted right after frame end");

    // A write to the ToS register reads back on the next cycle.
    a_tos_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && !paddr[2]) ##1 !paddr[2] |->
            prdata == {24'd0, $past(pwdata[7:0])})
        else $error("ToS register readback mismatch");

    // A write to the source octet register keeps only six bits.
    a_src_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && paddr[2]) ##1 paddr[2] |->
            prdata == {26'd0, $past(pwdata[5:0])})
        else $error("source octet register readback mismatch");

endmodule

bind ipv4_header_rewrite_checksum_top ihrc_checker u_ihrc_checker (.*);

// File: bench/ihrc_frame_checker.sv
`timescale 1ns / 100ps
// Scoreboard that predicts the rewritten byte stream and checks the output channel against it.
module ihrc_frame_checker
#(
    parameter int DELAY_DEPTH = 60
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    input  logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          error_count,
    output int          pending_count,
    output int          result_count,
    output int          frame_count
);
    import ihrc_pkg::*;

    typedef struct
    {
        logic [7:0] data;
        logic [6:0] pos;
    } held_byte_t;

    typedef struct
    {
        logic [7:0] data;
        logic       tail;
    } frame_out_t;

    held_byte_t delay_bytes[$];
    frame_out_t rewritten_bytes[$];

    logic [7:0]  tos_value;
    logic [5:0]  src_octet;
    logic [6:0]  byte_pos;
    logic        ipv4_frame;
    logic [3:0]  ihl;
    logic [21:0] header_sum;
    int          mismatch_total;
    int          results_total;
    int          frames_total;

    function automatic logic [15:0] folded_checksum();
        logic [31:0] s;
        s = {10'd0, header_sum};
        s = (s & 32'h0000_FFFF) + (s >> 16);
        s = (s & 32'h0000_FFFF) + (s >> 16);
        return ~s[15:0];
    endfunction

    // The check field is filled in only when the byte leaves the delay line,
    // so it carries the sum as it stands at that moment.
    function automatic logic [7:0] patched_byte(held_byte_t h);
        logic [15:0] ck;
        ck = folded_checksum();
        if (ipv4_frame && h.pos == POS_CK_HI)
            return ck[15:8];
        if (ipv4_frame && h.pos == POS_CK_LO)
            return ck[7:0];
        return h.data;
    endfunction

    task automatic absorb_frame_byte(input logic [7:0] b_in, input logic tail);
        logic [7:0] b;
        logic [6:0] p;
        held_byte_t h;
        frame_out_t o;
        b = b_in;
        p = byte_pos;
        if (p == POS_ETYPE_HI)
            ipv4_frame = (b == ETYPE_IPV4_HI);
        else if (p == POS_ETYPE_LO)
            ipv4_frame = ipv4_frame && (b == ETYPE_IPV4_LO);

        if (ipv4_frame && p >= POS_IP_START)
        begin
            if (p == POS_IP_START)
                ihl = b[3:0];
            if (p == POS_TOS)
                b = tos_value;
            if (p == POS_SRC_LOW)
                b = {2'b00, src_octet};
            // Header words are summed with the check field taken as zero.
            if (int'(p) < int'(POS_IP_START) + 4 * int'(ihl) &&
                p != POS_CK_HI && p != POS_CK_LO)
            begin
                if (p[0] == 1'b0)
                    header_sum = header_sum + {6'd0, b, 8'h00};
                else
                    header_sum = header_sum + {14'd0, b};
            end
        end

        if (delay_bytes.size() >= DELAY_DEPTH)
        begin
            h = delay_bytes.pop_front();
            o.data = patched_byte(h);
            o.tail = 1'b0;
            rewritten_bytes.insert(rewritten_bytes.size(), o);
        end
        h.data = b;
        h.pos = p;
        delay_bytes.insert(delay_bytes.size(), h);

        if (tail)
        begin
            while (delay_bytes.size() > 0)
            begin
                h = delay_bytes.pop_front();
                o.data = patched_byte(h);
                o.tail = (delay_bytes.size() == 0);
                rewritten_bytes.insert(rewritten_bytes.size(), o);
            end
            byte_pos = '0;
            ipv4_frame = 1'b0;
            ihl = '0;
            header_sum = '0;
            frames_total++;
        end
        else if (p != POS_MAX)
        begin
            byte_pos = p + 7'd1;
        end
    endtask

    task automatic check_output_byte(input logic [7:0] data, input logic tail);
        frame_out_t want;
        results_total++;
        if (rewritten_bytes.size() == 0)
        begin
            $error("unexpected output byte %h (tlast %b) with nothing pending", data, tail);
            mismatch_total++;
        end
        else
        begin
            want = rewritten_bytes.pop_front();
            if (want.data !== data)
            begin
                $error("out_byte mismatch: expected %h, got %h", want.data, data);
                mismatch_total++;
            end
            if (want.tail !== tail)
            begin
                $error("out_end mismatch: expected %b, got %b", want.tail, tail);
                mismatch_total++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_bytes.delete();
            rewritten_bytes.delete();
            tos_value = TOS_RESET;
            src_octet = SRC_LOW_RESET;
            byte_pos = '0;
            ipv4_frame = 1'b0;
            ihl = '0;
            header_sum = '0;
            mismatch_total = 0;
            results_total = 0;
            frames_total = 0;
            error_count <= 0;
            pending_count <= 0;
            result_count <= 0;
            frame_count <= 0;
        end
        else
        begin
            // Outputs first: a byte leaving now never stems from the byte entering now.
            if (m_axis_tvalid && m_axis_tready)
                check_output_byte(m_axis_tdata, m_axis_tlast);
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[2])
                    REG_NEW_TOS: tos_value = pwdata[7:0];
                    REG_SRC_LOW: src_octet = pwdata[5:0];
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                absorb_frame_byte(s_axis_tdata, s_axis_tlast);
            error_count <= mismatch_total;
            pending_count <= rewritten_bytes.size();
            result_count <= results_total;
            frame_count <= frames_total;
        end
    end

endmodule

// File: bench/tb_ipv4_header_rewrite_checksum_top.sv
`timescale 1ns / 100ps
// Testbench top: frame stimulus, register writes and the verdict for the rewrite block.
module tb_ipv4_header_rewrite_checksum_top;
    import ihrc_pkg::*;

    localparam int DELAY_DEPTH = 60;
    // Far above the slowest legal run: a few hundred frame bytes, each waiting
    // out receiver stalls, plus the delay-line drain of every frame.
    localparam int CYCLE_LIMIT = 200000;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;  // bits [7:0]: frame_byte
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // bits [7:0]: out_byte
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int cycle_count = 0;
    int error_count;
    int pending_count;
    int result_count;
    int frame_count;

    ipv4_header_rewrite_checksum_top
    #(
        .DELAY_DEPTH(DELAY_DEPTH)
    )
    dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    ihrc_frame_checker
    #(
        .DELAY_DEPTH(DELAY_DEPTH)
    )
    checker_i
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .pready(pready),
        .error_count(error_count),
        .pending_count(pending_count),
        .result_count(result_count),
        .frame_count(frame_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // The receiver stalls at random, at the rate set for the current phase.
    always @(posedge clk)
    begin
        m_axis_tready <= rst_n && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // One byte transfer on the input channel. Random idle cycles come before
    // the byte is offered; once offered, tvalid stays high until it is taken.
    task automatic send_xfer(input logic [7:0] data, input logic tail);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= data;
        s_axis_tlast <= tail;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // A frame of random bytes with the EtherType and the IHL nibble placed.
    task automatic send_frame(input int len, input logic [15:0] etype, input logic [3:0] ihl);
        for (int i = 0; i < len; i++)
        begin
            logic [7:0] b;
            b = 8'($urandom_range(0, 255));
            if (i == int'(POS_ETYPE_HI))
                b = etype[15:8];
            if (i == int'(POS_ETYPE_LO))
                b = etype[7:0];
            if (i == int'(POS_IP_START))
                b = {4'h4, ihl};
            send_xfer(b, i == len - 1);
        end
    endtask

    // Mostly well-formed IPv4 frames with random content; the rest carry a
    // broken or foreign EtherType. Lengths span short frames, frames that end
    // inside the header, and frames long enough to stream through the line.
    task automatic send_random_frames(input int budget);
        int sent;
        int len;
        logic [15:0] etype;
        logic [3:0] ihl;
        sent = 0;
        while (sent < budget)
        begin
            if ($urandom_range(0, 99) < 75)
            begin
                etype = {ETYPE_IPV4_HI, ETYPE_IPV4_LO};
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0: etype = {ETYPE_IPV4_HI, 8'($urandom_range(1, 255))};
                    1: etype = {8'($urandom_range(0, 255)), ETYPE_IPV4_LO};
                    default: etype = 16'($urandom);
                endcase
            end
            ihl = ($urandom_range(0, 99) < 70) ? 4'd5 : 4'($urandom_range(0, 15));
            len = ($urandom_range(0, 99) < 20) ? $urandom_range(1, 33) : $urandom_range(34, 80);
            send_frame(len, etype, ihl);
            sent += len;
        end
    endtask

    // Lets every expected byte arrive, then a full drain time more, so that
    // a register write never lands while the block still holds frame data.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DELAY_DEPTH + 4) @(posedge clk);
    endtask

    // Setup cycle, then access cycle; pready is always high.
    task automatic apb_write(input logic idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase one: the sender idles rarely and the receiver often.
        tx_idle_pct = 13;
        rx_idle_pct = 55;

        // Directed frames under the reset register values: one-byte frames at
        // both byte extremes, an IPv4 frame that ends early inside a header
        // that claims the largest IHL (missing bytes count as zero, the ToS
        // byte is still rewritten), and a frame too short to carry an EtherType.
        send_xfer(8'hFF, 1'b1);
        send_xfer(8'h00, 1'b1);
        send_frame(16, {ETYPE_IPV4_HI, ETYPE_IPV4_LO}, 4'hF);
        send_frame(8, {ETYPE_IPV4_HI, ETYPE_IPV4_LO}, 4'h5);
        settle();

        // Low extreme for ToS, a value near the top of the six-bit range for the source octet.
        apb_write(REG_NEW_TOS, 32'd0);
        apb_write(REG_SRC_LOW, 32'd59);
        // IHL zero: nothing is summed and the checksum comes out as all ones,
        // yet the check field and the source octet are still replaced.
        send_frame(30, {ETYPE_IPV4_HI, ETYPE_IPV4_LO}, 4'h0);
        send_random_frames(1);
        settle();

        // Phase two: the idle rates swap sides.
        tx_idle_pct = 55;
        rx_idle_pct = 13;
        apb_write(REG_NEW_TOS, 32'd255);
        apb_write(REG_SRC_LOW, 32'd0);
        // Largest header, long enough that bytes stream out before the end
        // and that the byte counter saturates.
        send_frame(130, {ETYPE_IPV4_HI, ETYPE_IPV4_LO}, 4'hF);
        settle();

        // Phase three: no idling on either side, random mid-range settings.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        apb_write(REG_NEW_TOS, 32'($urandom_range(1, 254)));
        apb_write(REG_SRC_LOW, 32'($urandom_range(1, 58)));
        send_random_frames(1);
        settle();

        $display("Checked %0d output bytes from %0d frames (IPv4 and other EtherTypes,",
                 result_count, frame_count);
        $display("short and long) under four register settings and three stall patterns.");
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: files.f
src/ihrc_pkg.sv
src/ihrc_ctrl.sv
src/ihrc_datapath.sv
src/ipv4_header_rewrite_checksum_top.sv
src/ihrc_checker.sv
bench/ihrc_frame_checker.sv
bench/tb_ipv4_header_rewrite_checksum_top.sv
